// ===== src/owb_pkg.sv =====
// owb_pkg: shared types, codes and constants of the one-wire bus master core
// no dependencies; imported by owb_fsm and one_wire_bus_master_core
package owb_pkg;

  // tick counter width and saturation value
  localparam int CNT_W = 12;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // width of a duration register and of the config index
  localparam int REG_W = 12;
  localparam int IDX_W = 3;

  // compare width covers both the counter and the duration registers
  localparam int CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;

  // duration register reset values
  localparam logic [REG_W-1:0] RST_RESET_LOW    = REG_W'(500);
  localparam logic [REG_W-1:0] RST_PRES_WAIT    = REG_W'(70);
  localparam logic [REG_W-1:0] RST_RESET_REC    = REG_W'(500);
  localparam logic [REG_W-1:0] RST_WRITE_START  = REG_W'(10);
  localparam logic [REG_W-1:0] RST_WRITE_DATA   = REG_W'(50);
  localparam logic [REG_W-1:0] RST_READ_LOW     = REG_W'(5);
  localparam logic [REG_W-1:0] RST_READ_SAMPLE  = REG_W'(5);
  localparam logic [REG_W-1:0] RST_READ_REC     = REG_W'(50);

  // config register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_RESET_LOW   = 3'd0,
    REG_PRES_WAIT   = 3'd1,
    REG_RESET_REC   = 3'd2,
    REG_WRITE_START = 3'd3,
    REG_WRITE_DATA  = 3'd4,
    REG_READ_LOW    = 3'd5,
    REG_READ_SAMPLE = 3'd6,
    REG_READ_REC    = 3'd7
  } reg_idx_t;

  // commands carried by a tick
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  // sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_W_START  = 4'd4,
    PH_W_DATA   = 4'd5,
    PH_W_GAP    = 4'd6,
    PH_R_LOW    = 4'd7,
    PH_R_WAIT   = 4'd8,
    PH_R_REC    = 4'd9,
    PH_R_GAP    = 4'd10
  } phase_t;

  // all duration registers
  typedef struct packed {
    logic [REG_W-1:0] reset_low_ticks;
    logic [REG_W-1:0] presence_wait_ticks;
    logic [REG_W-1:0] reset_recovery_ticks;
    logic [REG_W-1:0] write_start_ticks;
    logic [REG_W-1:0] write_data_ticks;
    logic [REG_W-1:0] read_low_ticks;
    logic [REG_W-1:0] read_sample_ticks;
    logic [REG_W-1:0] read_recovery_ticks;
  } owb_cfg_t;

  // one result beat
  typedef struct packed {
    logic       pull_low;
    logic       busy_res;
    logic       finished;
    logic       device_present;
    logic [7:0] read_byte;
  } owb_result_t;

endpackage

// ===== src/owb_fsm.sv =====
// owb_fsm: tick sequencer of the one-wire bus master (reset, write and read slots)
// depends on owb_pkg; state advances once per accepted tick
module owb_fsm
  import owb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [1:0]  opcode,
  input  logic [7:0]  write_byte,
  input  logic        line_level,
  input  owb_cfg_t    cfg,
  output owb_result_t result
);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] tick_count, tick_count_next;
  logic [2:0]       bit_index, bit_index_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic             presence_flag, presence_flag_next;
  logic [7:0]       received_byte, received_byte_next;

  logic [CNT_W-1:0] tick_inc;
  logic [REG_W-1:0] len_sel;
  logic             expired;
  logic             fin;
  logic             pull;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      received_byte <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      received_byte <= received_byte_next;
    end
  end

  // saturating counter and the duration of the current phase
  always_comb begin
    tick_inc = (tick_count < CNT_MAX) ? tick_count + 1'b1 : tick_count;
    case (phase)
      PH_RST_LOW:  len_sel = cfg.reset_low_ticks;
      PH_RST_WAIT: len_sel = cfg.presence_wait_ticks;
      PH_RST_REC:  len_sel = cfg.reset_recovery_ticks;
      PH_W_START:  len_sel = cfg.write_start_ticks;
      PH_W_DATA:   len_sel = cfg.write_data_ticks;
      PH_R_LOW:    len_sel = cfg.read_low_ticks;
      PH_R_WAIT:   len_sel = cfg.read_sample_ticks;
      PH_R_REC:    len_sel = cfg.read_recovery_ticks;
      default:     len_sel = '0;
    endcase
    expired = (CMP_W'(tick_inc) >= CMP_W'(len_sel)) || (tick_inc == CNT_MAX);
  end

  // next state
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    received_byte_next = received_byte;
    fin                = 1'b0;
    case (phase)
      PH_IDLE: begin
        tick_count_next = '0;
        case (opcode)
          OP_RESET: begin
            phase_next = PH_RST_LOW;
          end
          OP_WRITE: begin
            shift_byte_next = write_byte;
            bit_index_next  = '0;
            phase_next      = PH_W_START;
          end
          OP_READ: begin
            shift_byte_next = '0;
            bit_index_next  = '0;
            phase_next      = PH_R_LOW;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      PH_RST_LOW, PH_W_START, PH_W_DATA, PH_R_LOW, PH_RST_REC, PH_R_REC: begin
        tick_count_next = tick_inc;
        if (expired) begin
          tick_count_next = '0;
          case (phase)
            PH_RST_LOW: phase_next = PH_RST_WAIT;
            PH_W_START: phase_next = PH_W_DATA;
            PH_W_DATA:  phase_next = PH_W_GAP;
            PH_R_LOW:   phase_next = PH_R_WAIT;
            PH_R_REC:   phase_next = PH_R_GAP;
            default: begin
              phase_next = PH_IDLE;
              fin        = 1'b1;
            end
          endcase
        end
      end
      PH_RST_WAIT: begin
        tick_count_next = tick_inc;
        if (expired) begin
          presence_flag_next = ~line_level;
          tick_count_next    = '0;
          phase_next         = PH_RST_REC;
        end
      end
      PH_R_WAIT: begin
        tick_count_next = tick_inc;
        if (expired) begin
          shift_byte_next = {line_level, shift_byte[7:1]};
          tick_count_next = '0;
          phase_next      = PH_R_REC;
        end
      end
      PH_W_GAP: begin
        shift_byte_next = {1'b0, shift_byte[7:1]};
        tick_count_next = '0;
        if (bit_index == 3'd7) begin
          bit_index_next = '0;
          phase_next     = PH_IDLE;
          fin            = 1'b1;
        end else begin
          bit_index_next = bit_index + 1'b1;
          phase_next     = PH_W_START;
        end
      end
      PH_R_GAP: begin
        tick_count_next = '0;
        if (bit_index == 3'd7) begin
          bit_index_next     = '0;
          received_byte_next = shift_byte;
          phase_next         = PH_IDLE;
          fin                = 1'b1;
        end else begin
          bit_index_next = bit_index + 1'b1;
          phase_next     = PH_R_LOW;
        end
      end
      default: begin
        tick_count_next = '0;
        phase_next      = PH_IDLE;
      end
    endcase
  end

  // line drive follows the state after this tick
  always_comb begin
    case (phase_next)
      PH_RST_LOW, PH_W_START, PH_R_LOW: pull = 1'b1;
      PH_W_DATA:                        pull = ~shift_byte_next[0];
      default:                          pull = 1'b0;
    endcase
    result.pull_low       = pull;
    result.busy_res       = (phase_next != PH_IDLE);
    result.finished       = fin;
    result.device_present = presence_flag_next;
    result.read_byte      = received_byte_next;
  end

  // sequencing checks
  a_bit_index_idle: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (bit_index == 3'd0))
    else $error("bit index not cleared while idle");
  a_gap_no_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_W_GAP || phase == PH_R_GAP) |-> (tick_count == '0))
    else $error("tick counter running in a gap tick");
  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(tick_count))
    else $error("sequencer moved without an accepted tick");

endmodule

// ===== src/one_wire_bus_master_core.sv =====
// one_wire_bus_master_core: top level of the one-wire bus master
// depends on owb_pkg and owb_fsm
//
// Usage
//   Input channel (in_valid / in_stall): one beat per time-base tick, with
//   opcode (none, reset, write byte, read byte), write_byte and the sampled
//   line_level. Commands arriving while a sequence runs are ignored.
//   Output channel (out_valid / out_stall): one beat per input beat, giving
//   pull_low for the open-drain line, busy_res, a finished pulse, the
//   presence flag of the last reset and the last byte read.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): writes one
//   of the eight 12-bit tick-count registers; cfg_ready is always high.
// Timing
//   One input beat per cycle while the skid is empty; its result beat is
//   registered in out_reg (in the skid under out_stall). The sequencer
//   update is a single pass of logic between the state and result registers.
// Reset
//   rst clears the sequencer to idle, the presence flag and read byte to
//   zero, loads the default tick counts and empties the output registers.
// Stall
//   While out_stall holds a result, one more input beat is still taken into a
//   one-beat skid register; in_stall rises only while the skid is full.
module one_wire_bus_master_core
  import owb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       opcode,
  input  logic [7:0]       write_byte,
  input  logic             line_level,
  // output channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic             pull_low,
  output logic             busy_res,
  output logic             finished,
  output logic             device_present,
  output logic [7:0]       read_byte,
  // config channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  owb_cfg_t    cfg;
  owb_result_t res_new;
  owb_result_t out_reg;
  owb_result_t skid_reg;
  logic        skid_valid;
  logic        in_fire;
  logic        out_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_fire   = in_valid && !skid_valid;
  assign out_fire  = out_valid && !out_stall;

  // duration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks      <= RST_RESET_LOW;
      cfg.presence_wait_ticks  <= RST_PRES_WAIT;
      cfg.reset_recovery_ticks <= RST_RESET_REC;
      cfg.write_start_ticks    <= RST_WRITE_START;
      cfg.write_data_ticks     <= RST_WRITE_DATA;
      cfg.read_low_ticks       <= RST_READ_LOW;
      cfg.read_sample_ticks    <= RST_READ_SAMPLE;
      cfg.read_recovery_ticks  <= RST_READ_REC;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_RESET_LOW:   cfg.reset_low_ticks      <= cfg_data;
        REG_PRES_WAIT:   cfg.presence_wait_ticks  <= cfg_data;
        REG_RESET_REC:   cfg.reset_recovery_ticks <= cfg_data;
        REG_WRITE_START: cfg.write_start_ticks    <= cfg_data;
        REG_WRITE_DATA:  cfg.write_data_ticks     <= cfg_data;
        REG_READ_LOW:    cfg.read_low_ticks       <= cfg_data;
        REG_READ_SAMPLE: cfg.read_sample_ticks    <= cfg_data;
        REG_READ_REC:    cfg.read_recovery_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  owb_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .step       (in_fire),
    .opcode     (opcode),
    .write_byte (write_byte),
    .line_level (line_level),
    .cfg        (cfg),
    .result     (res_new)
  );

  // output register with one-beat skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_reg   <= res_new;
        out_valid <= 1'b1;
      end else begin
        skid_reg   <= res_new;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign pull_low       = out_reg.pull_low;
  assign busy_res       = out_reg.busy_res;
  assign finished       = out_reg.finished;
  assign device_present = out_reg.device_present;
  assign read_byte      = out_reg.read_byte;

  // buffer and result checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat while the output register is empty");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (in_fire && out_valid && out_stall) |=> skid_valid)
    else $error("beat accepted under stall was not kept in the skid");
  a_fin_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && finished) |-> !busy_res)
    else $error("finished pulse while still busy");
  a_pull_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pull_low) |-> busy_res)
    else $error("line driven low while idle");

endmodule
